/* design/act_pkg.sv */
// ============================================================================
// act_pkg
// Shared types, widths and tables for the calibrated tilt core.
// ============================================================================
package act_pkg;

    // Datapath widths
    localparam int ACC_W   = 19;   // corrected axis, Q9.10
    localparam int NUM_W   = 20;   // lane numerator (negated axis fits)
    localparam int SQ_W    = 37;   // one square
    localparam int RAD_W   = 58;   // radicand: sum of squares << 20
    localparam int ROOT_W  = 29;   // floor square root of radicand
    localparam int REM_W   = 32;   // square root remainder
    localparam int CX_W    = 33;   // CORDIC x / y
    localparam int Z_W     = 27;   // CORDIC angle accumulator, 2^-24 rad
    localparam int ANG_W   = 15;   // output angle, Q2.13
    localparam int GRAV_W  = 15;
    localparam int TAB_LEN = 24;
    localparam int TAB_IW  = 5;
    localparam int TAB_W   = 25;

    localparam logic signed [ANG_W-1:0] ANG_MAX     = 15'sd12868;
    localparam logic [GRAV_W-1:0]       GRAV_RESET  = 15'd10042;
    localparam logic                    REG_GRAVITY = 1'b0;

    // Arctangent of 2^-i in units of 2^-24 rad
    localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
        25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331,
        25'd1047214,  25'd524117,  25'd262123,  25'd131069,
        25'd65536,    25'd32768,   25'd16384,   25'd8192,
        25'd4096,     25'd2048,    25'd1024,    25'd512,
        25'd256,      25'd128,     25'd64,      25'd32,
        25'd16,       25'd8,       25'd4,       25'd2
    };

    typedef enum logic [2:0] {
        LN_IDLE, LN_SQR, LN_SUM, LN_ROOT, LN_ROT, LN_FIN
    } t_lane_st;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_DIV, ST_LANE, ST_OUT
    } t_top_st;

    // Launch request for one angle lane
    typedef struct packed {
        logic                     start;
        logic signed [NUM_W-1:0]  num;
        logic signed [ACC_W-1:0]  a;
        logic signed [ACC_W-1:0]  b;
    } t_lane_req;

endpackage

/* design/act_div.sv */
// ============================================================================
// act_div
// Rounded average: sum / N, half away from zero, by reciprocal multiply.
// ============================================================================
module act_div #(
    parameter int N     = 64,
    parameter int SUM_W = 29
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [SUM_W-1:0]              i_sum,
    output logic                                 o_done,
    output logic signed [act_pkg::ACC_W-1:0]     o_quot
);
    // dividend < 2^DW; K >= DW + log2(N) keeps floor(d * RECIP / 2^K) exact
    localparam int DW = SUM_W + 1;
    localparam int K  = DW + $clog2(N);
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;
    localparam logic [DW-1:0] HALF  = DW'(N / 2);
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'(N) - 64'd1) / 64'(N));

    logic                          r_busy;
    logic                          r_done;
    logic                          r_neg;
    logic [DW-1:0]                 r_dvd;
    logic [act_pkg::ACC_W-1:0]     r_q;

    logic [SUM_W-1:0]              mag;
    logic [PW-1:0]                 prod;

    // magnitude and scaled product
    always_comb begin
        mag  = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        prod = PW'(r_dvd) * PW'(RECIP);
    end

    // control: load, multiply, done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {1'b0, mag} + HALF;
            r_neg <= i_sum[SUM_W-1];
        end
        if (r_busy) begin
            r_q <= prod[K +: act_pkg::ACC_W];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

/* design/act_lane.sv */
// ============================================================================
// act_lane
// One tilt lane: atan2(num, sqrt(a^2 + b^2)) by square root and CORDIC.
// ============================================================================
module act_lane #(
    parameter int STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  act_pkg::t_lane_req                  i_req,
    output logic                                o_done,
    output logic signed [act_pkg::ANG_W-1:0]    o_angle
);
    localparam int ROOT_W = act_pkg::ROOT_W;
    localparam int REM_W  = act_pkg::REM_W;
    localparam int RAD_W  = act_pkg::RAD_W;
    localparam int CX_W   = act_pkg::CX_W;
    localparam int Z_W    = act_pkg::Z_W;
    localparam int IW     = act_pkg::TAB_IW;
    localparam logic [IW-1:0] ROOT_LAST = IW'(ROOT_W - 1);
    localparam logic [IW-1:0] ROT_LAST  = IW'(STEPS - 1);

    act_pkg::t_lane_st r_state, n_state;

    logic signed [act_pkg::NUM_W-1:0] r_num;
    logic signed [act_pkg::ACC_W-1:0] r_a, r_b;
    logic [act_pkg::SQ_W-1:0]         r_sqa, r_sqb;
    logic [RAD_W-1:0]                 r_rad;
    logic [REM_W-1:0]                 r_rem;
    logic [ROOT_W-1:0]                r_root;
    logic [IW-1:0]                    r_cnt;
    logic signed [CX_W-1:0]           r_x, r_y;
    logic signed [Z_W-1:0]            r_z;
    logic                             r_zero;
    logic                             r_done;
    logic signed [act_pkg::ANG_W-1:0] r_angle;

    logic signed [2*act_pkg::ACC_W-1:0] prod_a, prod_b;
    logic [act_pkg::SQ_W:0]           sq_sum;
    logic [REM_W-1:0]                 rem_sh, trial;
    logic                             ge;
    logic [ROOT_W-1:0]                root_nx;
    logic signed [CX_W-1:0]           dx, dy, y_init;
    logic signed [Z_W-1:0]            tab, z_rnd, z_sh;

    // per-step arithmetic
    always_comb begin
        prod_a  = r_a * r_a;
        prod_b  = r_b * r_b;
        sq_sum  = {1'b0, r_sqa} + {1'b0, r_sqb};
        rem_sh  = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial   = {1'b0, r_root, 2'b01};
        ge      = rem_sh >= trial;
        root_nx = {r_root[ROOT_W-2:0], ge};
        y_init  = CX_W'(r_num) <<< 10;
        dx      = r_y >>> r_cnt;
        dy      = r_x >>> r_cnt;
        tab     = $signed(Z_W'(act_pkg::ATAN_TAB[r_cnt]));
        z_rnd   = r_z + Z_W'(1024);
        z_sh    = z_rnd >>> 11;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            act_pkg::LN_IDLE: if (i_req.start) n_state = act_pkg::LN_SQR;
            act_pkg::LN_SQR:  n_state = act_pkg::LN_SUM;
            act_pkg::LN_SUM:  n_state = act_pkg::LN_ROOT;
            act_pkg::LN_ROOT: begin
                if (r_cnt == ROOT_LAST) begin
                    n_state = (root_nx == '0 && r_num == '0) ? act_pkg::LN_FIN
                                                            : act_pkg::LN_ROT;
                end
            end
            act_pkg::LN_ROT:  if (r_cnt == ROT_LAST) n_state = act_pkg::LN_FIN;
            act_pkg::LN_FIN:  n_state = act_pkg::LN_IDLE;
            default:          n_state = act_pkg::LN_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= act_pkg::LN_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == act_pkg::LN_FIN);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            act_pkg::LN_IDLE: begin
                r_num <= i_req.num;
                r_a   <= i_req.a;
                r_b   <= i_req.b;
            end
            act_pkg::LN_SQR: begin
                r_sqa <= act_pkg::SQ_W'(prod_a);
                r_sqb <= act_pkg::SQ_W'(prod_b);
            end
            act_pkg::LN_SUM: begin
                r_rad  <= {sq_sum, 20'b0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            act_pkg::LN_ROOT: begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= ge ? rem_sh - trial : rem_sh;
                r_root <= root_nx;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == ROOT_LAST) begin
                    r_x    <= $signed(CX_W'(root_nx));
                    r_y    <= y_init;
                    r_z    <= '0;
                    r_cnt  <= '0;
                    r_zero <= (root_nx == '0 && r_num == '0);
                end
            end
            act_pkg::LN_ROT: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + tab;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - tab;
                end
            end
            act_pkg::LN_FIN: begin
                if (r_zero) begin
                    r_angle <= '0;
                end else if (z_sh > Z_W'(act_pkg::ANG_MAX)) begin
                    r_angle <= act_pkg::ANG_MAX;
                end else if (z_sh < -Z_W'(act_pkg::ANG_MAX)) begin
                    r_angle <= -act_pkg::ANG_MAX;
                end else begin
                    r_angle <= act_pkg::ANG_W'(z_sh);
                end
            end
            default: ;
        endcase
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

/* design/accel_calibrated_tilt_core.sv */
// ============================================================================
// accel_calibrated_tilt_core
// Accelerometer offset calibration, corrected axes, roll/pitch and vertical
// acceleration.
// ============================================================================
// One item is handled at a time. A measurement beat with a good read has its
// result computed by two parallel angle lanes that each run a bit-pair square
// root and CORDIC_STEPS CORDIC steps, plus capture, squaring, rounding and
// merging; an all-zero corrected vector skips the CORDIC steps. The beat that
// completes a calibration run also waits for the three reciprocal-multiply
// rounding dividers. The input stays stalled until the result is loaded, so
// the next beat is accepted in the cycle after that at the earliest. A
// finished result waits in the output register while the next beat is
// accepted. gravity sits at APB byte address 0.
module accel_calibrated_tilt_core #(
    parameter int CAL_SAMPLES  = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_func,
    input  logic                                 i_read_ok,
    input  logic signed [17:0]                   i_accel_x,
    input  logic signed [17:0]                   i_accel_y,
    input  logic signed [17:0]                   i_accel_z,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [18:0]                   o_corr_x,
    output logic signed [18:0]                   o_corr_y,
    output logic signed [18:0]                   o_corr_z,
    output logic signed [14:0]                   o_roll_angle,
    output logic signed [14:0]                   o_pitch_angle,
    output logic signed [18:0]                   o_vertical_accel,
    output logic                                 o_motion_valid,
    output logic                                 o_calibration_done
);
    localparam int SUM_W = 20 + $clog2(CAL_SAMPLES + 1);
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAL_SAMPLES);
    localparam int ACC_W = act_pkg::ACC_W;
    localparam int ANG_W = act_pkg::ANG_W;
    localparam logic signed [21:0] SAT_MAX = 22'sd262143;
    localparam logic signed [21:0] SAT_MIN = -22'sd262144;

    act_pkg::t_top_st r_state, n_state;

    // configuration
    logic [act_pkg::GRAV_W-1:0] r_gravity;
    logic                       wr_en;

    // captured beat
    logic                       r_func, r_ok;
    logic signed [17:0]         r_ax, r_ay, r_az;

    // calibration state
    logic signed [SUM_W-1:0]    r_sum_x, r_sum_y, r_sum_z;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [ACC_W-1:0]    r_off_x, r_off_y, r_off_z;
    logic                       r_calibrated;

    // working result
    logic signed [ACC_W-1:0]    r_cx, r_cy, r_cz, r_vert;
    logic signed [ANG_W-1:0]    r_roll, r_pitch;
    logic                       r_mv;

    // output register
    logic                       r_out_valid;
    logic signed [ACC_W-1:0]    r_o_cx, r_o_cy, r_o_cz, r_o_vert;
    logic signed [ANG_W-1:0]    r_o_roll, r_o_pitch;
    logic                       r_o_mv, r_o_cd;

    logic signed [SUM_W-1:0]    sum_x_nx, sum_y_nx, sum_z_nx;
    logic [CNT_W-1:0]           cnt_nx;
    logic                       run_end, cal_add, meas;
    logic signed [21:0]         dx, dy, dz, dv;
    logic signed [ACC_W-1:0]    cx, cy, cz, cv;
    logic                       accept, load_out;
    logic                       div_done_x, div_done_y, div_done_z;
    logic signed [ACC_W-1:0]    q_x, q_y, q_z;
    logic                       roll_done, pitch_done;
    logic signed [ANG_W-1:0]    roll_ang, pitch_ang;
    act_pkg::t_lane_req         roll_req, pitch_req;

    function automatic logic signed [ACC_W-1:0] sat19(input logic signed [21:0] v);
        if (v > SAT_MAX)      sat19 = SAT_MAX[ACC_W-1:0];
        else if (v < SAT_MIN) sat19 = SAT_MIN[ACC_W-1:0];
        else                  sat19 = v[ACC_W-1:0];
    endfunction

    // APB: single register
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == act_pkg::REG_GRAVITY);
    assign prdata = (paddr[2] == act_pkg::REG_GRAVITY) ? 32'(r_gravity) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gravity <= act_pkg::GRAV_RESET;
        else if (wr_en) r_gravity <= pwdata[act_pkg::GRAV_W-1:0];
    end

    // beat accumulation and correction
    always_comb begin
        sum_x_nx = r_sum_x + SUM_W'(r_ax);
        sum_y_nx = r_sum_y + SUM_W'(r_ay);
        sum_z_nx = r_sum_z + SUM_W'(r_az) - SUM_W'($signed({1'b0, r_gravity}));
        cnt_nx   = r_cnt + 1'b1;
        cal_add  = (r_state == act_pkg::ST_EXEC) && !r_func && r_ok;
        run_end  = cal_add && (cnt_nx == CNT_FULL);
        meas     = (r_state == act_pkg::ST_EXEC) && r_func && r_ok;
        dx = 22'(r_ax) - 22'(r_off_x);
        dy = 22'(r_ay) - 22'(r_off_y);
        dz = 22'(r_az) - 22'(r_off_z);
        dv = dz - 22'($signed({1'b0, r_gravity}));
        cx = sat19(dx);
        cy = sat19(dy);
        cz = sat19(dz);
        cv = sat19(dv);
        roll_req.start  = meas;
        roll_req.num    = act_pkg::NUM_W'(cy);
        roll_req.a      = cx;
        roll_req.b      = cz;
        pitch_req.start = meas;
        pitch_req.num   = -act_pkg::NUM_W'(cx);
        pitch_req.a     = cy;
        pitch_req.b     = cz;
    end

    act_div #(.N(CAL_SAMPLES), .SUM_W(SUM_W)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(run_end), .i_sum(sum_x_nx),
        .o_done(div_done_x), .o_quot(q_x)
    );
    act_div #(.N(CAL_SAMPLES), .SUM_W(SUM_W)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(run_end), .i_sum(sum_y_nx),
        .o_done(div_done_y), .o_quot(q_y)
    );
    act_div #(.N(CAL_SAMPLES), .SUM_W(SUM_W)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(run_end), .i_sum(sum_z_nx),
        .o_done(div_done_z), .o_quot(q_z)
    );

    act_lane #(.STEPS(CORDIC_STEPS)) u_lane_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(roll_req),
        .o_done(roll_done), .o_angle(roll_ang)
    );
    act_lane #(.STEPS(CORDIC_STEPS)) u_lane_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(pitch_req),
        .o_done(pitch_done), .o_angle(pitch_ang)
    );

    // control
    assign o_in_stall = (r_state != act_pkg::ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign load_out   = (r_state == act_pkg::ST_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            act_pkg::ST_IDLE: if (accept) n_state = act_pkg::ST_EXEC;
            act_pkg::ST_EXEC: begin
                if (run_end)   n_state = act_pkg::ST_DIV;
                else if (meas) n_state = act_pkg::ST_LANE;
                else           n_state = act_pkg::ST_OUT;
            end
            act_pkg::ST_DIV:  if (div_done_x && div_done_y && div_done_z)
                                  n_state = act_pkg::ST_OUT;
            act_pkg::ST_LANE: if (roll_done && pitch_done) n_state = act_pkg::ST_OUT;
            act_pkg::ST_OUT:  if (load_out) n_state = act_pkg::ST_IDLE;
            default:          n_state = act_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= act_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x      <= '0;
            r_sum_y      <= '0;
            r_sum_z      <= '0;
            r_cnt        <= '0;
            r_off_x      <= '0;
            r_off_y      <= '0;
            r_off_z      <= '0;
            r_calibrated <= 1'b0;
        end else begin
            if (run_end) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_sum_z <= '0;
                r_cnt   <= '0;
            end else if (cal_add) begin
                r_sum_x <= sum_x_nx;
                r_sum_y <= sum_y_nx;
                r_sum_z <= sum_z_nx;
                r_cnt   <= cnt_nx;
            end
            if (r_state == act_pkg::ST_DIV && div_done_x) begin
                r_off_x      <= q_x;
                r_off_y      <= q_y;
                r_off_z      <= q_z;
                r_calibrated <= 1'b1;
            end
        end
    end

    // beat capture and working result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_ok   <= i_read_ok;
            r_ax   <= i_accel_x;
            r_ay   <= i_accel_y;
            r_az   <= i_accel_z;
        end
        if (r_state == act_pkg::ST_EXEC) begin
            r_cx    <= meas ? cx : '0;
            r_cy    <= meas ? cy : '0;
            r_cz    <= meas ? cz : '0;
            r_vert  <= meas ? cv : '0;
            r_mv    <= meas;
            r_roll  <= '0;
            r_pitch <= '0;
        end
        if (r_state == act_pkg::ST_LANE && roll_done) begin
            r_roll  <= roll_ang;
            r_pitch <= pitch_ang;
        end
    end

    // merge into output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_cx    <= r_cx;
            r_o_cy    <= r_cy;
            r_o_cz    <= r_cz;
            r_o_vert  <= r_vert;
            r_o_roll  <= r_roll;
            r_o_pitch <= r_pitch;
            r_o_mv    <= r_mv;
            r_o_cd    <= r_calibrated;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_corr_x           = r_o_cx;
    assign o_corr_y           = r_o_cy;
    assign o_corr_z           = r_o_cz;
    assign o_roll_angle       = r_o_roll;
    assign o_pitch_angle      = r_o_pitch;
    assign o_vertical_accel   = r_o_vert;
    assign o_motion_valid     = r_o_mv;
    assign o_calibration_done = r_o_cd;

endmodule
